[rtl/tgadec_pkg.sv]
// Shared types and constants of the run-length coded TGA pixel decoder.
// No dependencies; every other file of the decoder imports this package.
package tgadec_pkg;

  localparam int BYTE_W     = 8;
  localparam int COLOUR_W   = 32;
  localparam int REP_W      = 8;
  localparam int PIX_W      = 32;
  localparam int DIM_W      = 16;
  localparam int BPP_W      = 3;
  localparam int POS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int SETTLE_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  localparam logic [BPP_W-1:0]  BPP_FOUR   = 3'd4;
  localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd3;
  localparam logic [BYTE_W-1:0] RUN_BIAS   = 8'd127;
  localparam int                RUN_FLAG   = 7;
  localparam logic [POS_W-1:0]  POS_LAST3  = 2'd2;
  localparam logic [POS_W-1:0]  POS_LAST4  = 2'd3;

  // Settle countdown after a configuration write
  localparam logic [SETTLE_W-1:0] SETTLE_START   = 2'd2;
  localparam logic [SETTLE_W-1:0] SETTLE_REFRESH = 2'd1;
  localparam logic [SETTLE_W-1:0] SETTLE_DONE    = 2'd0;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // One finished colour handed from the front to the back
  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic                four;
    logic [REP_W-1:0]    rep;
    logic                last;
    logic                clip;
  } pix_rec_t;

endpackage

[rtl/tgadec_if.sv]
// Valid/ready channel interfaces of the TGA pixel decoder: byte input, pixel output.
// Depends on tgadec_pkg for field widths.
interface tgadec_in_if;
  import tgadec_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tgadec_out_if;
  import tgadec_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;
  logic [REP_W-1:0]  repeat_count;
  logic              last_of_image;
  logic              clipped;
  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_count, output last_of_image, output clipped,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_count, input last_of_image, input clipped,
                  output ready);
endinterface

[rtl/tgadec_front.sv]
// Front of the TGA decoder: configuration, packet headers, colour assembly and
// pixel accounting. Depends on tgadec_pkg; feeds tgadec_fifo.
module tgadec_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tgadec_pkg::cfg_write_t cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  output logic                   push,
  output tgadec_pkg::pix_rec_t   push_rec,
  input  logic                   q_full
);
  import tgadec_pkg::*;

  logic [DIM_W-1:0]    width_r, width_nxt;
  logic [DIM_W-1:0]    height_r, height_nxt;
  logic [BPP_W-1:0]    bpp_r, bpp_nxt;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic [PIX_W-1:0]    total_r, total_nxt;
  logic [PIX_W-1:0]    left_r, left_nxt;
  logic [PIX_W-1:0]    done_r, done_nxt;
  logic                expect_hdr_r, expect_hdr_nxt;
  logic                is_run_r, is_run_nxt;
  logic [REP_W-1:0]    pr_r, pr_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [COLOUR_W-1:0] holder_r, holder_nxt;

  logic [DIM_W-1:0]    w_eff, h_eff;
  logic [PIX_W-1:0]    left_cfg;
  logic                accept, four, colour_done, left_hi;
  logic [REP_W-1:0]    left_lo, rep, pr_after;
  logic                last, clip;
  logic [COLOUR_W-1:0] holder_upd;

  assign in_ready = (settle_r == SETTLE_DONE) && !q_full;
  assign accept   = in_valid && in_ready;

  // Zero dimension counts as one
  assign w_eff     = (width_r == '0) ? DIM_W'(1) : width_r;
  assign h_eff     = (height_r == '0) ? DIM_W'(1) : height_r;
  assign total_nxt = PIX_W'(w_eff) * PIX_W'(h_eff);
  assign left_cfg  = (done_r < total_r) ? (total_r - done_r) : PIX_W'(1);

  assign four        = (bpp_r == BPP_FOUR);
  assign colour_done = (pos_r >= (four ? POS_LAST4 : POS_LAST3));

  always_comb begin
    holder_upd = holder_r;
    for (int k = 0; k < 4; k++) begin
      if (pos_r == POS_W'(k)) begin
        holder_upd[BYTE_W*k +: BYTE_W] = in_byte;
      end
    end
  end

  // Pixels left always fit in 8 bits when the upper part is clear
  assign left_hi = |left_r[PIX_W-1:REP_W];
  assign left_lo = left_r[REP_W-1:0];

  always_comb begin
    if (is_run_r) begin
      clip     = !left_hi && (pr_r > left_lo);
      rep      = clip ? left_lo : pr_r;
      last     = !left_hi && (pr_r >= left_lo);
      pr_after = '0;
    end else begin
      last     = !left_hi && (left_lo == REP_W'(1));
      clip     = last && (pr_r > REP_W'(1));
      rep      = REP_W'(1);
      pr_after = (pr_r != '0) ? (pr_r - REP_W'(1)) : '0;
    end
  end

  assign push     = accept && !expect_hdr_r && colour_done;
  assign push_rec = '{colour: holder_upd, four: four, rep: rep, last: last, clip: clip};

  always_comb begin
    width_nxt      = width_r;
    height_nxt     = height_r;
    bpp_nxt        = bpp_r;
    settle_nxt     = settle_r;
    left_nxt       = left_r;
    done_nxt       = done_r;
    expect_hdr_nxt = expect_hdr_r;
    is_run_nxt     = is_run_r;
    pr_nxt         = pr_r;
    pos_nxt        = pos_r;
    holder_nxt     = holder_r;

    if (cfg.we) begin
      settle_nxt = SETTLE_START;
      case (cfg.index)
        REG_IMAGE_WIDTH:     width_nxt  = cfg.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    height_nxt = cfg.data[DIM_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_nxt    = cfg.data[BPP_W-1:0];
        default: ;
      endcase
    end else if (settle_r != SETTLE_DONE) begin
      settle_nxt = settle_r - SETTLE_W'(1);
    end

    if (accept) begin
      if (expect_hdr_r) begin
        is_run_nxt     = in_byte[RUN_FLAG];
        pr_nxt         = in_byte[RUN_FLAG] ? (in_byte - RUN_BIAS) : (in_byte + REP_W'(1));
        expect_hdr_nxt = 1'b0;
        pos_nxt        = '0;
      end else begin
        holder_nxt = holder_upd;
        if (!colour_done) begin
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          pos_nxt = '0;
          if (last) begin
            done_nxt       = '0;
            left_nxt       = total_r;
            pr_nxt         = '0;
            expect_hdr_nxt = 1'b1;
          end else begin
            done_nxt       = done_r + PIX_W'(rep);
            left_nxt       = left_r - PIX_W'(rep);
            pr_nxt         = pr_after;
            expect_hdr_nxt = (pr_after == '0);
          end
        end
      end
    end else if (settle_r == SETTLE_REFRESH) begin
      // Product is registered by now; refresh the pixels still owed
      left_nxt = left_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= DIM_W'(1);
      height_r     <= DIM_W'(1);
      bpp_r        <= BPP_RESET;
      settle_r     <= SETTLE_DONE;
      total_r      <= PIX_W'(1);
      left_r       <= PIX_W'(1);
      done_r       <= '0;
      expect_hdr_r <= 1'b1;
      is_run_r     <= 1'b0;
      pr_r         <= '0;
      pos_r        <= '0;
      holder_r     <= '0;
    end else begin
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      bpp_r        <= bpp_nxt;
      settle_r     <= settle_nxt;
      total_r      <= total_nxt;
      left_r       <= left_nxt;
      done_r       <= done_nxt;
      expect_hdr_r <= expect_hdr_nxt;
      is_run_r     <= is_run_nxt;
      pr_r         <= pr_nxt;
      pos_r        <= pos_nxt;
      holder_r     <= holder_nxt;
    end
  end

endmodule

[rtl/tgadec_fifo.sv]
// Two-entry queue of finished colours between the decoder front and back.
// Depends on tgadec_pkg for the record type and depth.
module tgadec_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tgadec_pkg::pix_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output tgadec_pkg::pix_rec_t pop_rec,
  output logic                 empty
);
  import tgadec_pkg::*;

  pix_rec_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_rec = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + QPTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? (rd_ptr_r + QPTR_W'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[rtl/tgadec_back.sv]
// Back of the TGA decoder: channel swap, alpha gating and the output register.
// Depends on tgadec_pkg; drains tgadec_fifo.
module tgadec_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  tgadec_pkg::pix_rec_t q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha,
  output logic [7:0]           out_rep,
  output logic                 out_last,
  output logic                 out_clip
);
  import tgadec_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic [REP_W-1:0]  rep_r;
  logic              last_r, clip_r;

  // Load whenever the output register is free or being drained
  assign q_pop = !q_empty && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      blue_r  <= q_rec.colour[0*BYTE_W +: BYTE_W];
      green_r <= q_rec.colour[1*BYTE_W +: BYTE_W];
      red_r   <= q_rec.colour[2*BYTE_W +: BYTE_W];
      alpha_r <= q_rec.four ? q_rec.colour[3*BYTE_W +: BYTE_W] : '0;
      rep_r   <= q_rec.rep;
      last_r  <= q_rec.last;
      clip_r  <= q_rec.clip;
    end
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;
  assign out_rep   = rep_r;
  assign out_last  = last_r;
  assign out_clip  = clip_r;

endmodule

[rtl/tga_rle_pixel_decoder.sv]
// Run-length coded TGA pixel decoder, 24/32-bit colour. Feed the pixel-data
// bytes one per request on in_ch; each completed colour leaves on out_ch as one
// request with red and blue in their usual places, a repeat count (1..128 for a
// run, 1 for a raw pixel), and flags for the last pixel of the image and for a
// packet cut short at the image end. The decoder takes one byte per cycle while
// in_ch.ready is high and gives at most one result per byte, so an unstalled
// stream moves at a byte per clock; the pixel accounting that decides the next
// header sits in the byte front. A two-entry queue and the output register let
// the front keep taking bytes while a result waits. in_ch.ready drops after
// every configuration write while the width-times-height product (one 16x16
// multiplier) and the pixels still owed are recomputed, and whenever the queue
// is full. There is no clearing pass after reset.
// Depends on tgadec_pkg, tgadec_if, tgadec_front, tgadec_fifo, tgadec_back.
module tga_rle_pixel_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  tgadec_in_if.sink                           in_ch,
  tgadec_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [tgadec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgadec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tgadec_pkg::*;

  cfg_write_t cfg;
  pix_rec_t   push_rec, pop_rec;
  logic       q_push, q_full, q_pop, q_empty;

  // Bundle the write port for the front, which owns the registers
  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_wdata};

  // Front: header decode, colour gathering, clipping and end-of-image tracking
  tgadec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .push     (q_push),
    .push_rec (push_rec),
    .q_full   (q_full)
  );

  // Queue: decouple the byte side from output stalls
  tgadec_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  // Back: reorder channels, gate alpha, hold the result until taken
  tgadec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_red   (out_ch.red),
    .out_green (out_ch.green),
    .out_blue  (out_ch.blue),
    .out_alpha (out_ch.alpha),
    .out_rep   (out_ch.repeat_count),
    .out_last  (out_ch.last_of_image),
    .out_clip  (out_ch.clipped)
  );

  // Hold off bytes while the pixel total settles after a write
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("byte accepted while configuration settles");

  // Drop nothing: the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue overflow");

  // A cut packet always ends the image
  a_clip_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.clipped || out_ch.last_of_image))
    else $error("clipped result not marked last of image");

  // Every result covers at least one pixel
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.repeat_count != '0))
    else $error("zero repeat count");

endmodule

[test/tb.sv]
// Testbench for tga_rle_pixel_decoder: feeds run-length coded pixel bytes and
// checks every pixel result against a behavioral decoder kept in this file.
// Depends on tgadec_pkg, tgadec_if and the decoder RTL.
`timescale 1ns / 100ps

module tb;
  import tgadec_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 600;
  localparam int SETTLE_CYCLES = 8;    // front, queue and output register, with margin
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 200;  // long receiver hold-off that backs up the input
  localparam int SCRIPT_LEN    = 30;
  localparam int NUM_FIELDS    = 7;

  localparam logic [CFG_IDX_W-1:0] NO_REG = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [REP_W-1:0]  rep;
    logic              last;
    logic              clip;
  } pixel_t;

  localparam pixel_t NO_PIXEL = '0;

  typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;   // register data, or the byte in the low bits
    logic                  typed;   // pixel below is the literal expected result
    pixel_t                pixel;
  } script_row_t;

  // Directed opening. Typed pixels are the ones that follow from the rules
  // directly; every other row goes through the behavioral decoder.
  script_row_t directed_script [SCRIPT_LEN] = '{
    // 1x1 BGR image after reset: a 128-pixel run cut down to the one pixel
    '{ROW_BYTE, NO_REG, 16'h00FF, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h00FF, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0000, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h00AA, 1'b1,
      '{8'hAA, 8'h00, 8'hFF, 8'h00, 8'd1, 1'b1, 1'b1}},
    // raw packet of two colours, the image ends after the first one
    '{ROW_BYTE, NO_REG, 16'h0001, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0000, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0000, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0000, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1, 1'b1}},
    // zero width counts as one: 1x2 image of BGRA colours, run of one
    '{ROW_CFG, REG_IMAGE_WIDTH, 16'd0, 1'b0, NO_PIXEL},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 16'd2, 1'b0, NO_PIXEL},
    '{ROW_CFG, REG_BYTES_PER_PIXEL, 16'd4, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0080, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0001, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0002, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0003, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0004, 1'b1,
      '{8'h03, 8'h02, 8'h01, 8'h04, 8'd1, 1'b0, 1'b0}},
    // raw packet of one colour, stop one byte short of the colour
    '{ROW_BYTE, NO_REG, 16'h0000, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0011, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0022, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0033, 1'b0, NO_PIXEL},
    // unknown pixel size acts as BGR, so the colour is already past its end;
    // shrink the image to the pixels already done, so this pixel ends it
    '{ROW_CFG, REG_BYTES_PER_PIXEL, 16'd7, 1'b0, NO_PIXEL},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 16'd1, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0044, 1'b1,
      '{8'h33, 8'h22, 8'h11, 8'h00, 8'd1, 1'b1, 1'b0}},
    // largest image, widest raw packet, left open for the random part
    '{ROW_CFG, REG_IMAGE_WIDTH, 16'hFFFF, 1'b0, NO_PIXEL},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 16'hFFFF, 1'b0, NO_PIXEL},
    '{ROW_CFG, REG_BYTES_PER_PIXEL, 16'd3, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h007F, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0001, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0002, 1'b0, NO_PIXEL},
    '{ROW_BYTE, NO_REG, 16'h0003, 1'b0, NO_PIXEL}
  };

  string field_names [NUM_FIELDS] = '{"red", "green", "blue", "alpha",
                                       "repeat_count", "last_of_image", "clipped"};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic [31:0]           cycle_count = '0;

  tgadec_in_if  in_ch ();
  tgadec_out_if out_ch ();

  tga_rle_pixel_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Behavioral decoder: register copies, packet state and pixel accounting
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  logic [BPP_W-1:0]    bpp_reg;
  logic                awaiting_header;
  logic                run_packet;
  logic [REP_W-1:0]    pixels_owed;
  logic [POS_W-1:0]    next_byte_pos;
  logic [COLOUR_W-1:0] colour_word;
  logic [PIX_W-1:0]    pixels_emitted;

  pixel_t pixel_forecast [$];   // pixels still to come out, oldest first

  // Mode flags set by the byte feeder; the pixel drain reads the stall and hold-off flags
  bit sender_gaps     = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_pending    = 1'b0;

  int unsigned bytes_fed, pixels_checked, images_ended, clipped_seen;
  int unsigned reg_writes, phases_run, errors;

  // Hard stop: a hung handshake or a missing pixel lands here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still awaited",
               cycle_count, pixel_forecast.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic reset_decoder_model();
    width_reg       = 16'd1;
    height_reg      = 16'd1;
    bpp_reg         = BPP_RESET;
    awaiting_header = 1'b1;
    run_packet      = 1'b0;
    pixels_owed     = '0;
    next_byte_pos   = '0;
    colour_word     = '0;
    pixels_emitted  = '0;
  endtask

  // Advance the model by one byte; emits is set when a colour completes.
  task automatic decode_byte(input logic [BYTE_W-1:0] b, output bit emits,
                             output pixel_t px);
    logic [PIX_W-1:0] total, left, rep;
    logic [POS_W-1:0] final_pos;
    logic             four, clip, last;
    emits = 1'b0;
    px    = NO_PIXEL;
    if (awaiting_header) begin
      run_packet      = b[RUN_FLAG];
      pixels_owed     = b[RUN_FLAG] ? b - RUN_BIAS : b + 8'd1;
      awaiting_header = 1'b0;
      next_byte_pos   = '0;
    end else begin
      four      = (bpp_reg == BPP_FOUR);
      final_pos = four ? POS_LAST4 : POS_LAST3;
      colour_word[8*next_byte_pos +: 8] = b;
      if (next_byte_pos < final_pos) begin
        next_byte_pos = next_byte_pos + 2'd1;
      end else begin
        next_byte_pos = '0;
        // zero dimensions count as one; past the end, one pixel is left
        total = {16'd0, (width_reg == 0) ? 16'd1 : width_reg} *
                {16'd0, (height_reg == 0) ? 16'd1 : height_reg};
        left  = (pixels_emitted < total) ? total - pixels_emitted : 32'd1;
        if (run_packet) begin
          rep  = {24'd0, pixels_owed};
          clip = rep > left;
          if (clip) rep = left;
          pixels_owed = '0;
        end else begin
          rep  = 32'd1;
          clip = (left == 1) && (pixels_owed > 1);
          pixels_owed = (pixels_owed != 0) ? pixels_owed - 8'd1 : 8'd0;
        end
        last = (rep == left);
        if (last) begin
          pixels_emitted  = '0;
          pixels_owed     = '0;
          awaiting_header = 1'b1;
        end else begin
          pixels_emitted = pixels_emitted + rep;
          if (pixels_owed == 0) awaiting_header = 1'b1;
        end
        emits     = 1'b1;
        px.red    = colour_word[23:16];
        px.green  = colour_word[15:8];
        px.blue   = colour_word[7:0];
        px.alpha  = four ? colour_word[31:24] : 8'd0;
        px.rep    = rep[REP_W-1:0];
        px.last   = last;
        px.clip   = clip;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what);
    if (errors < 40) $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Offer one byte request after a random gap; predict once it is taken.
  task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input pixel_t typed_px);
    int unsigned gap;
    bit          emits;
    pixel_t      px;
    gap = sender_gaps ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_fed++;
    decode_byte(b, emits, px);
    if (emits) pixel_forecast.push_back(typed ? typed_px : px);
  endtask

  // Drop valid, wait out every awaited pixel, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pixel_forecast.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write at the next falling edge; the model takes it right away,
  // since no byte can be accepted before the write lands.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    reg_writes++;
    case (idx)
      REG_IMAGE_WIDTH:     width_reg  = val;
      REG_IMAGE_HEIGHT:    height_reg = val;
      REG_BYTES_PER_PIXEL: bpp_reg    = val[BPP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small images so that images end often; now and then the extremes.
  function automatic logic [DIM_W-1:0] pick_dimension();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return DIM_W'($urandom_range(0, 16'hFFFF));
      default: return DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [BPP_W-1:0] pick_pixel_size();
    case ($urandom_range(0, 9))
      0, 1:    return BPP_W'($urandom_range(0, 7));
      2, 3, 4: return BPP_RESET;
      default: return BPP_FOUR;
    endcase
  endfunction

  // Headers favor short runs and short raw packets so packets close inside
  // the phase; the rest spans the whole byte.
  function automatic logic [BYTE_W-1:0] pick_header();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: return 8'h80 | BYTE_W'($urandom_range(0, 7));
      8, 9, 10, 11, 12, 13:   return BYTE_W'($urandom_range(0, 5));
      14, 15, 16:             return BYTE_W'($urandom_range(128, 255));
      default:                return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_colour_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Pixel drain: random stalls, one long hold-off, and the field check
  // ---------------------------------------------------------------------
  initial begin : drain_pixels
    int unsigned       stall;
    pixel_t            want;
    logic [BYTE_W-1:0] got_f  [NUM_FIELDS];
    logic [BYTE_W-1:0] want_f [NUM_FIELDS];
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = receiver_stalls ? $urandom_range(0, 15) : 0;
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_ch.valid === 1'b1));
      pixels_checked++;
      if (out_ch.last_of_image === 1'b1) images_ended++;
      if (out_ch.clipped === 1'b1) clipped_seen++;
      if (pixel_forecast.size() == 0) begin
        report_mismatch("pixel request with nothing awaited");
      end else begin
        want   = pixel_forecast.pop_front();
        got_f  = '{out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                   out_ch.repeat_count, {7'd0, out_ch.last_of_image},
                   {7'd0, out_ch.clipped}};
        want_f = '{want.red, want.green, want.blue, want.alpha, want.rep,
                   {7'd0, want.last}, {7'd0, want.clip}};
        for (int f = 0; f < NUM_FIELDS; f++) begin
          if (got_f[f] !== want_f[f])
            report_mismatch($sformatf("pixel %0d %s got %h want %h",
                                      pixels_checked, field_names[f],
                                      got_f[f], want_f[f]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Byte feeder and run control
  // ---------------------------------------------------------------------
  initial begin : feed_bytes
    int unsigned phase_len, sent_in_phase;
    logic [BYTE_W-1:0] b;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= NO_REG;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    reset_decoder_model();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; each block of register rows starts from idle.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (directed_script[i].kind == ROW_CFG) begin
        if (i == 0 || directed_script[i-1].kind != ROW_CFG) settle();
        write_reg(directed_script[i].index, directed_script[i].value);
        if (i + 1 == SCRIPT_LEN || directed_script[i+1].kind != ROW_CFG) close_writes();
      end else begin
        feed_byte(directed_script[i].value[BYTE_W-1:0], directed_script[i].typed,
                  directed_script[i].pixel);
      end
    end

    // Random phases: new geometry and pixel size while idle, then a stream
    // of headers and colour bytes that ends at an arbitrary byte, often in
    // the middle of a packet or of a colour.
    while (bytes_fed < SCRIPT_LEN + RANDOM_BYTES) begin
      phases_run++;
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, pick_dimension());
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, pick_dimension());
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(pick_pixel_size()));
      close_writes();
      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      phase_len       = $urandom_range(8, 70);
      if (phases_run == 2) begin
        // hold the drain off while bytes keep coming back to back
        sender_gaps  = 1'b0;
        hold_pending = 1'b1;
        phase_len    = 80;
      end
      for (sent_in_phase = 0; sent_in_phase < phase_len; sent_in_phase++) begin
        b = awaiting_header ? pick_header() : pick_colour_byte();
        feed_byte(b, 1'b0, NO_PIXEL);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("fed %0d bytes over %0d random phases with %0d register writes",
             bytes_fed, phases_run, reg_writes);
    $display("checked %0d pixel results: %0d ended an image, %0d were clipped",
             pixels_checked, images_ended, clipped_seen);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
